// ===== design/jsu_pkg.sv =====
// Shared types, codes and helpers for the JSON string unescaper.
package jsu_pkg;

    localparam int BYTE_W    = 8;
    localparam int UNIT_W    = 16;
    localparam int KIND_W    = 2;
    localparam int MAX_RES   = 8;
    localparam int RES_IDX_W = $clog2(MAX_RES);
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);
    localparam int HELD_D    = 5;
    localparam int QUEUE_D   = HELD_D + 1;
    localparam int QUEUE_W   = $clog2(QUEUE_D + 1);
    localparam int QIDX_W    = $clog2(QUEUE_D);
    localparam int ACC_W     = 31;

    localparam logic [KIND_W-1:0] KIND_UNIT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUOTE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END    = 2'd2;

    typedef enum logic [1:0] {
        MODE_PLAIN = 2'd0,
        MODE_ESC   = 2'd1,
        MODE_HEX   = 2'd2,
        MODE_UTF   = 2'd3
    } mode_t;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
        logic drain_adv;
    } jsu_cmd_t;

    typedef struct packed {
        logic done;
        logic fin_nonempty;
        logic drain_last;
    } jsu_sts_t;

    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] r;
        r = 5'h10;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b0, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b0, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b0, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

// ===== design/json_string_unescape_utf16_core.sv =====
// Top level of the JSON string unescaper, UTF-8 bytes in, UTF-16 code units out.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_in_byte, s_end_of_data
//  m_      | out       | m_valid / m_ready  | m_code_unit, m_unit_kind, m_last_of_run
//
// Each byte is loaded, stepped through the decoder (again when an escape is re-read or
// held bytes are replayed), finished, and its results then drain from the result
// buffer. The single decode unit and the result buffer, filled before it drains, mean
// that the next byte is taken only once the last one is through.
// Reset is synchronous, active low, and returns the decoder to plain text.
// A stalled m_ready holds the buffered results; no byte is taken until all are out.
module json_string_unescape_utf16_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [jsu_pkg::BYTE_W-1:0]    s_in_byte,
    input  logic                          s_end_of_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [jsu_pkg::UNIT_W-1:0]    m_code_unit,
    output logic [jsu_pkg::KIND_W-1:0]    m_unit_kind,
    output logic                          m_last_of_run
);
    import jsu_pkg::*;

    jsu_cmd_t cmd;
    jsu_sts_t sts;

    jsu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    jsu_dpath u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_in_byte     (s_in_byte),
        .s_end_of_data (s_end_of_data),
        .cmd           (cmd),
        .sts           (sts),
        .m_code_unit   (m_code_unit),
        .m_unit_kind   (m_unit_kind),
        .m_last_of_run (m_last_of_run)
    );

endmodule

// ===== design/jsu_ctrl.sv =====
// Controller: sequences load, byte steps, finish and result drain.
module jsu_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    output logic             m_valid,
    input  logic             m_ready,
    output jsu_pkg::jsu_cmd_t cmd,
    input  jsu_pkg::jsu_sts_t sts
);
    import jsu_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_PROC  = 2'd1,
        ST_FIN   = 2'd2,
        ST_DRAIN = 2'd3
    } state_t;

    state_t state_reg;
    logic   s_ready_reg;
    logic   m_valid_reg;

    assign s_ready = s_ready_reg && aresetn;
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd           = '0;
        cmd.load      = (state_reg == ST_IDLE) && s_valid && s_ready;
        cmd.step      = (state_reg == ST_PROC);
        cmd.finish    = (state_reg == ST_FIN);
        cmd.drain_adv = (state_reg == ST_DRAIN) && m_valid_reg && m_ready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_ready_reg <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready_reg) begin
                        state_reg   <= ST_PROC;
                        s_ready_reg <= 1'b0;
                    end
                end
                ST_PROC: begin
                    if (sts.done) begin
                        state_reg <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    if (sts.fin_nonempty) begin
                        state_reg   <= ST_DRAIN;
                        m_valid_reg <= 1'b1;
                    end else begin
                        state_reg   <= ST_IDLE;
                        s_ready_reg <= 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (m_ready && sts.drain_last) begin
                        state_reg   <= ST_IDLE;
                        m_valid_reg <= 1'b0;
                        s_ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg   <= ST_IDLE;
                    s_ready_reg <= 1'b1;
                    m_valid_reg <= 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== design/jsu_dpath.sv =====
// Datapath: decode state, replay queue and result buffer.
module jsu_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [jsu_pkg::BYTE_W-1:0]    s_in_byte,
    input  logic                          s_end_of_data,
    input  jsu_pkg::jsu_cmd_t             cmd,
    output jsu_pkg::jsu_sts_t             sts,
    output logic [jsu_pkg::UNIT_W-1:0]    m_code_unit,
    output logic [jsu_pkg::KIND_W-1:0]    m_unit_kind,
    output logic                          m_last_of_run
);
    import jsu_pkg::*;

    typedef enum logic [1:0] {
        ACT_CONSUME = 2'd0,
        ACT_AGAIN   = 2'd1,
        ACT_RPL_HEX = 2'd2,
        ACT_RPL_UTF = 2'd3
    } act_t;

    mode_t                 mode_reg, mode_next;
    logic [BYTE_W-1:0]     held_reg [HELD_D];
    logic [2:0]            hc_reg, hc_next;
    logic [2:0]            nc_reg, nc_next;
    logic [ACC_W-1:0]      acc_reg, acc_next;

    logic [BYTE_W-1:0]     cur_reg;
    logic                  cur_eod_reg;
    logic                  item_eod_reg;
    logic [BYTE_W-1:0]     q_reg [QUEUE_D];
    logic [QUEUE_W-1:0]    q_rd_reg;
    logic [QUEUE_W-1:0]    q_len_reg;
    logic                  q_eod_reg;

    logic [UNIT_W-1:0]     ru_reg [MAX_RES];
    logic [KIND_W-1:0]     rk_reg [MAX_RES];
    logic [RES_CNT_W-1:0]  cnt_reg;
    logic [RES_IDX_W-1:0]  rd_reg;
    logic                  closed_reg;

    act_t                  act;
    logic [1:0]            ne;
    logic [UNIT_W-1:0]     e_u [2];
    logic [KIND_W-1:0]     e_k [2];
    logic                  held_we;
    logic [BYTE_W-1:0]     hx [QUEUE_D];
    logic [BYTE_W-1:0]     q_new [QUEUE_D];
    logic [QUEUE_W-1:0]    len_new;
    logic [4:0]            hv;
    logic [ACC_W-1:0]      acc6;
    logic [ACC_W-1:0]      usub;
    logic [2:0]            lead_n;
    logic [BYTE_W-1:0]     b;
    logic                  eod;
    logic                  rewind;
    logic [QUEUE_W-1:0]    rw_idx;

    assign b   = cur_reg;
    assign eod = cur_eod_reg;
    assign hv  = hex_value(b);
    assign acc6 = {acc_reg[ACC_W-7:0], b[5:0]};
    assign usub = acc6 - ACC_W'(32'h10000);

    // a bad hex escape inside a replay re-reads its digits from the queue
    assign rewind = (act == ACT_RPL_HEX) && (q_rd_reg < q_len_reg);
    assign rw_idx = q_rd_reg - QUEUE_W'(hc_reg) - QUEUE_W'(1);

    always_comb begin
        for (int i = 0; i < HELD_D; i++) begin
            hx[i] = held_reg[i];
        end
        hx[HELD_D] = b;
    end

    always_comb begin
        lead_n = 3'd0;
        if (!b[5]) begin
            lead_n = 3'd2;
        end else if (!b[4]) begin
            lead_n = 3'd3;
        end else if (!b[3]) begin
            lead_n = 3'd4;
        end else if (!b[2]) begin
            lead_n = 3'd5;
        end else if (!b[1]) begin
            lead_n = 3'd6;
        end
    end

    always_comb begin
        act       = ACT_CONSUME;
        ne        = 2'd0;
        e_u[0]    = '0;
        e_u[1]    = '0;
        e_k[0]    = KIND_UNIT;
        e_k[1]    = KIND_UNIT;
        held_we   = 1'b0;
        mode_next = mode_reg;
        hc_next   = hc_reg;
        nc_next   = nc_reg;
        acc_next  = acc_reg;
        case (mode_reg)
            MODE_ESC: begin
                mode_next = MODE_PLAIN;
                ne        = 2'd1;
                case (b)
                    8'h22: e_u[0] = 16'h0022;
                    8'h5c: e_u[0] = 16'h005c;
                    8'h2f: e_u[0] = 16'h002f;
                    8'h62: e_u[0] = 16'h0008;
                    8'h66: e_u[0] = 16'h000c;
                    8'h6e: e_u[0] = 16'h000a;
                    8'h72: e_u[0] = 16'h000d;
                    8'h74: e_u[0] = 16'h0009;
                    8'h75: begin
                        if (eod) begin
                            ne     = 2'd2;
                            e_u[0] = 16'h005c;
                            e_u[1] = 16'h0075;
                        end else begin
                            ne        = 2'd0;
                            mode_next = MODE_HEX;
                            hc_next   = 3'd0;
                            acc_next  = '0;
                        end
                    end
                    default: begin
                        e_u[0] = 16'h005c;
                        act    = ACT_AGAIN;
                    end
                endcase
            end
            MODE_HEX: begin
                if (!hv[4] && hc_reg >= 3'd3) begin
                    ne        = 2'd1;
                    e_u[0]    = {acc_reg[11:0], hv[3:0]};
                    mode_next = MODE_PLAIN;
                    hc_next   = 3'd0;
                end else if (!hv[4] && !eod) begin
                    held_we  = 1'b1;
                    hc_next  = hc_reg + 3'd1;
                    acc_next = ACC_W'({acc_reg[11:0], hv[3:0]});
                end else begin
                    act       = ACT_RPL_HEX;
                    ne        = 2'd2;
                    e_u[0]    = 16'h005c;
                    e_u[1]    = 16'h0075;
                    mode_next = MODE_PLAIN;
                    hc_next   = 3'd0;
                end
            end
            MODE_UTF: begin
                if (nc_reg <= 3'd1) begin
                    acc_next  = acc6;
                    mode_next = MODE_PLAIN;
                    hc_next   = 3'd0;
                    nc_next   = 3'd0;
                    if (acc6[ACC_W-1:16] != '0) begin
                        ne     = 2'd2;
                        e_u[0] = UNIT_W'(32'hd800 + 32'(usub >> 10));
                        e_u[1] = UNIT_W'(32'hdc00 + 32'(usub & ACC_W'(32'h3ff)));
                    end else begin
                        ne     = 2'd1;
                        e_u[0] = acc6[15:0];
                    end
                end else if (!eod) begin
                    held_we  = (hc_reg < 3'(HELD_D));
                    hc_next  = hc_reg + 3'd1;
                    nc_next  = nc_reg - 3'd1;
                    acc_next = acc6;
                end else begin
                    act       = ACT_RPL_UTF;
                    ne        = 2'd1;
                    e_u[0]    = {8'h00, held_reg[0]};
                    mode_next = MODE_PLAIN;
                    hc_next   = 3'd0;
                    nc_next   = 3'd0;
                end
            end
            default: begin
                mode_next = MODE_PLAIN;
                if (b == 8'h5c) begin
                    if (eod) begin
                        ne     = 2'd1;
                        e_u[0] = 16'h005c;
                    end else begin
                        mode_next = MODE_ESC;
                    end
                end else if (b == 8'h22) begin
                    ne     = 2'd1;
                    e_k[0] = KIND_QUOTE;
                end else if (!b[7] || !b[6] || lead_n == 3'd0 || eod) begin
                    ne     = 2'd1;
                    e_u[0] = {8'h00, b};
                end else begin
                    held_we   = 1'b1;
                    hc_next   = 3'd1;
                    nc_next   = lead_n - 3'd1;
                    acc_next  = ACC_W'(b & (8'h7f >> lead_n));
                    mode_next = MODE_UTF;
                end
            end
        endcase
    end

    always_comb begin
        len_new = '0;
        for (int i = 0; i < QUEUE_D; i++) begin
            q_new[i] = b;
        end
        if (act == ACT_RPL_HEX) begin
            len_new = QUEUE_W'(hc_reg) + QUEUE_W'(1);
            for (int i = 0; i < QUEUE_D; i++) begin
                if (3'(i) < hc_reg) begin
                    q_new[i] = hx[i];
                end
            end
        end else begin
            len_new = QUEUE_W'(hc_reg);
            for (int i = 0; i < QUEUE_D - 1; i++) begin
                if (3'(i + 1) < hc_reg) begin
                    q_new[i] = hx[i + 1];
                end
            end
        end
    end

    always_comb begin
        sts              = '0;
        sts.done         = (act == ACT_CONSUME) && (q_rd_reg >= q_len_reg);
        sts.fin_nonempty = (cnt_reg != '0) || (item_eod_reg && !closed_reg);
        sts.drain_last   = (RES_CNT_W'(rd_reg) == cnt_reg - RES_CNT_W'(1));
    end

    assign m_code_unit   = ru_reg[rd_reg];
    assign m_unit_kind   = rk_reg[rd_reg];
    assign m_last_of_run = sts.drain_last;

    always_ff @(posedge aclk) begin
        if (cmd.step) begin
            if (held_we) begin
                held_reg[hc_reg] <= b;
            end
            for (int k = 0; k < 2; k++) begin
                if (2'(k) < ne && (cnt_reg + RES_CNT_W'(k)) < RES_CNT_W'(MAX_RES)) begin
                    ru_reg[RES_IDX_W'(cnt_reg + RES_CNT_W'(k))] <= e_u[k];
                    rk_reg[RES_IDX_W'(cnt_reg + RES_CNT_W'(k))] <= e_k[k];
                end
            end
            if (rewind) begin
                cur_reg <= q_reg[rw_idx[QIDX_W-1:0]];
            end else if (act == ACT_RPL_HEX || act == ACT_RPL_UTF) begin
                for (int i = 0; i < QUEUE_D; i++) begin
                    q_reg[i] <= q_new[i];
                end
                cur_reg <= q_new[0];
            end else if (act == ACT_CONSUME && q_rd_reg < q_len_reg) begin
                cur_reg <= q_reg[q_rd_reg[QIDX_W-1:0]];
            end
        end
        if (cmd.load) begin
            cur_reg <= s_in_byte;
        end
        if (cmd.finish && item_eod_reg && !closed_reg && cnt_reg < RES_CNT_W'(MAX_RES)) begin
            ru_reg[cnt_reg[RES_IDX_W-1:0]] <= '0;
            rk_reg[cnt_reg[RES_IDX_W-1:0]] <= KIND_END;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_PLAIN;
            hc_reg       <= '0;
            nc_reg       <= '0;
            acc_reg      <= '0;
            cur_eod_reg  <= 1'b0;
            item_eod_reg <= 1'b0;
            q_rd_reg     <= '0;
            q_len_reg    <= '0;
            q_eod_reg    <= 1'b0;
            cnt_reg      <= '0;
            rd_reg       <= '0;
            closed_reg   <= 1'b0;
        end else begin
            if (cmd.load) begin
                cur_eod_reg  <= s_end_of_data;
                item_eod_reg <= s_end_of_data;
                q_rd_reg     <= '0;
                q_len_reg    <= '0;
                cnt_reg      <= '0;
                rd_reg       <= '0;
                closed_reg   <= 1'b0;
            end
            if (cmd.step) begin
                mode_reg <= mode_next;
                hc_reg   <= hc_next;
                nc_reg   <= nc_next;
                acc_reg  <= acc_next;
                if (ne != 2'd0) begin
                    closed_reg <= (e_k[ne[1]] == KIND_QUOTE);
                end
                if (cnt_reg + RES_CNT_W'(ne) > RES_CNT_W'(MAX_RES)) begin
                    cnt_reg <= RES_CNT_W'(MAX_RES);
                end else begin
                    cnt_reg <= cnt_reg + RES_CNT_W'(ne);
                end
                if (rewind) begin
                    q_rd_reg <= rw_idx + QUEUE_W'(1);
                end else if (act == ACT_RPL_HEX || act == ACT_RPL_UTF) begin
                    q_rd_reg    <= QUEUE_W'(1);
                    q_len_reg   <= len_new;
                    q_eod_reg   <= eod;
                    cur_eod_reg <= eod && (len_new == QUEUE_W'(1));
                end else if (act == ACT_CONSUME && q_rd_reg < q_len_reg) begin
                    q_rd_reg    <= q_rd_reg + QUEUE_W'(1);
                    cur_eod_reg <= q_eod_reg && (q_rd_reg == q_len_reg - QUEUE_W'(1));
                end
            end
            if (cmd.finish) begin
                if (item_eod_reg) begin
                    mode_reg <= MODE_PLAIN;
                    hc_reg   <= '0;
                    nc_reg   <= '0;
                    acc_reg  <= '0;
                    if (!closed_reg && cnt_reg < RES_CNT_W'(MAX_RES)) begin
                        cnt_reg <= cnt_reg + RES_CNT_W'(1);
                    end
                end
            end
            if (cmd.drain_adv) begin
                rd_reg <= rd_reg + RES_IDX_W'(1);
            end
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// Self-checking testbench for the JSON string unescaper core (UTF-8 bytes in, UTF-16 out).
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import jsu_pkg::*;

    typedef struct packed {
        logic [15:0] unit;
        logic [1:0]  kind;
        logic        last;
    } unit_rec_t;

    typedef struct packed {
        logic [7:0]  b;
        logic        eod;
        logic [1:0]  nfix;
        logic [15:0] u0;
        logic [1:0]  k0;
        logic [15:0] u1;
        logic [1:0]  k1;
    } row_t;

    localparam int N_ROWS = 36;

    logic        aclk, aresetn;
    logic        s_valid, s_ready, s_end_of_data;
    logic [7:0]  s_in_byte;
    logic        m_valid, m_ready, m_last_of_run;
    logic [15:0] m_code_unit;
    logic [1:0]  m_unit_kind;

    unit_rec_t   units_due[$];
    int          n_errors, n_items, n_units, n_quotes, n_ends;
    int          m_hold;
    bit          no_idle;

    // decoder state
    mode_t       dec_mode;
    logic [7:0]  held [5];
    int          held_n, need_n;
    logic [30:0] acc;
    logic [15:0] out_u [8];
    logic [1:0]  out_k [8];
    int          out_n;
    bit          closed_last;

    row_t dir_rows [N_ROWS] = '{
        '{8'h41, 1'b0, 2'd1, 16'h0041, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'h00, 1'b0, 2'd1, 16'h0000, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'h7f, 1'b0, 2'd1, 16'h007f, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'h5c, 1'b0, 2'd0, 16'h0, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'h6e, 1'b0, 2'd1, 16'h000a, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'h5c, 1'b0, 2'd0, 16'h0, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'h75, 1'b0, 2'd0, 16'h0, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'h44, 1'b0, 2'd0, 16'h0, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'h38, 1'b0, 2'd0, 16'h0, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'h33, 1'b0, 2'd0, 16'h0, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'h64, 1'b0, 2'd1, 16'hd83d, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'h5c, 1'b0, 2'd0, 16'h0, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'h71, 1'b0, 2'd0, 16'h0, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'h5c, 1'b0, 2'd0, 16'h0, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'h75, 1'b0, 2'd0, 16'h0, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'h31, 1'b0, 2'd0, 16'h0, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'h67, 1'b0, 2'd0, 16'h0, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'hc3, 1'b0, 2'd0, 16'h0, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'ha9, 1'b0, 2'd0, 16'h0, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'hfd, 1'b0, 2'd0, 16'h0, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'hbf, 1'b0, 2'd0, 16'h0, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'hbf, 1'b0, 2'd0, 16'h0, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'hbf, 1'b0, 2'd0, 16'h0, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'hbf, 1'b0, 2'd0, 16'h0, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'hbf, 1'b0, 2'd0, 16'h0, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'h80, 1'b0, 2'd1, 16'h0080, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'hff, 1'b0, 2'd1, 16'h00ff, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'h22, 1'b0, 2'd1, 16'h0000, KIND_QUOTE, 16'h0, KIND_UNIT},
        '{8'h5c, 1'b0, 2'd0, 16'h0, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'h2f, 1'b0, 2'd1, 16'h002f, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'he2, 1'b0, 2'd0, 16'h0, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'h82, 1'b1, 2'd0, 16'h0, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'h5c, 1'b1, 2'd2, 16'h005c, KIND_UNIT, 16'h0000, KIND_END},
        '{8'h5c, 1'b0, 2'd0, 16'h0, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'h75, 1'b1, 2'd0, 16'h0, KIND_UNIT, 16'h0, KIND_UNIT},
        '{8'h22, 1'b1, 2'd1, 16'h0000, KIND_QUOTE, 16'h0, KIND_UNIT}
    };

    json_string_unescape_utf16_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_in_byte(s_in_byte), .s_end_of_data(s_end_of_data),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_code_unit(m_code_unit), .m_unit_kind(m_unit_kind),
        .m_last_of_run(m_last_of_run)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        n_errors++;
    endtask

    function automatic int hex_digit(input logic [7:0] b);
        if (b >= "0" && b <= "9") return int'(b) - 48;
        if (b >= "a" && b <= "f") return int'(b) - 87;
        if (b >= "A" && b <= "F") return int'(b) - 55;
        return -1;
    endfunction

    function automatic void put_unit(input logic [15:0] u, input logic [1:0] k);
        if (out_n < MAX_RES) begin
            out_u[out_n] = u;
            out_k[out_n] = k;
            out_n++;
        end
        closed_last = (k == KIND_QUOTE);
    endfunction

    function automatic void put_scalar(input logic [30:0] v);
        logic [31:0] w;
        if (v[30:16] != 0) begin
            w = {1'b0, v} - 32'h10000;
            put_unit(16'(32'hd800 + (w >> 10)), KIND_UNIT);
            put_unit(16'(32'hdc00 + (w & 32'h3ff)), KIND_UNIT);
        end else begin
            put_unit(v[15:0], KIND_UNIT);
        end
    endfunction

    function automatic void clear_decoder();
        dec_mode = MODE_PLAIN;
        held_n = 0;
        need_n = 0;
        acc = '0;
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input bit eod);
        logic [7:0] loc [6];
        int d, cnt, n;
        case (dec_mode)
            MODE_ESC: begin
                dec_mode = MODE_PLAIN;
                case (b)
                    8'h22: put_unit(16'h22, KIND_UNIT);
                    8'h5c: put_unit(16'h5c, KIND_UNIT);
                    8'h2f: put_unit(16'h2f, KIND_UNIT);
                    8'h62: put_unit(16'h08, KIND_UNIT);
                    8'h66: put_unit(16'h0c, KIND_UNIT);
                    8'h6e: put_unit(16'h0a, KIND_UNIT);
                    8'h72: put_unit(16'h0d, KIND_UNIT);
                    8'h74: put_unit(16'h09, KIND_UNIT);
                    8'h75: begin
                        if (eod) begin
                            put_unit(16'h5c, KIND_UNIT);
                            put_unit(16'h75, KIND_UNIT);
                        end else begin
                            dec_mode = MODE_HEX;
                            held_n = 0;
                            acc = '0;
                        end
                    end
                    default: begin
                        put_unit(16'h5c, KIND_UNIT);
                        decode_byte(b, eod);
                    end
                endcase
            end
            MODE_HEX: begin
                d = hex_digit(b);
                if (d >= 0 && held_n >= 3) begin
                    put_unit(16'({acc[11:0], 4'(d)}), KIND_UNIT);
                    dec_mode = MODE_PLAIN;
                    held_n = 0;
                end else if (d >= 0 && !eod) begin
                    held[held_n] = b;
                    held_n++;
                    acc = {15'd0, acc[11:0], 4'(d)};
                end else begin
                    cnt = held_n < 5 ? held_n : 5;
                    for (int i = 0; i < cnt; i++) loc[i] = held[i];
                    loc[cnt] = b;
                    n = cnt + 1;
                    dec_mode = MODE_PLAIN;
                    held_n = 0;
                    put_unit(16'h5c, KIND_UNIT);
                    put_unit(16'h75, KIND_UNIT);
                    for (int i = 0; i < n; i++) decode_byte(loc[i], eod && (i + 1 == n));
                end
            end
            MODE_UTF: begin
                if (need_n <= 1) begin
                    acc = {acc[24:0], b[5:0]};
                    dec_mode = MODE_PLAIN;
                    held_n = 0;
                    need_n = 0;
                    put_scalar(acc);
                end else if (!eod) begin
                    if (held_n < 5) held[held_n] = b;
                    held_n++;
                    need_n--;
                    acc = {acc[24:0], b[5:0]};
                end else begin
                    cnt = held_n < 5 ? held_n : 5;
                    for (int i = 0; i < cnt; i++) loc[i] = held[i];
                    loc[cnt] = b;
                    n = cnt + 1;
                    dec_mode = MODE_PLAIN;
                    held_n = 0;
                    need_n = 0;
                    put_unit({8'h00, loc[0]}, KIND_UNIT);
                    for (int i = 1; i < n; i++) decode_byte(loc[i], i + 1 == n);
                end
            end
            default: begin
                dec_mode = MODE_PLAIN;
                if (b == 8'h5c) begin
                    if (eod) put_unit(16'h5c, KIND_UNIT);
                    else dec_mode = MODE_ESC;
                end else if (b == 8'h22) begin
                    put_unit(16'h0, KIND_QUOTE);
                end else if (!b[7] || !b[6]) begin
                    put_unit({8'h00, b}, KIND_UNIT);
                end else begin
                    if (!b[5]) n = 2;
                    else if (!b[4]) n = 3;
                    else if (!b[3]) n = 4;
                    else if (!b[2]) n = 5;
                    else if (!b[1]) n = 6;
                    else n = 0;
                    if (n == 0 || eod) begin
                        put_unit({8'h00, b}, KIND_UNIT);
                    end else begin
                        held[0] = b;
                        held_n = 1;
                        need_n = n - 1;
                        acc = {23'd0, b & (8'h7f >> n)};
                        dec_mode = MODE_UTF;
                    end
                end
            end
        endcase
    endfunction

    function automatic void predict_units(input logic [7:0] b, input bit eod);
        out_n = 0;
        closed_last = 1'b0;
        decode_byte(b, eod);
        if (eod) begin
            if (!closed_last) put_unit(16'h0, KIND_END);
            clear_decoder();
        end
    endfunction

    function automatic void queue_predicted();
        for (int i = 0; i < out_n; i++)
            units_due.push_back('{out_u[i], out_k[i], i == out_n - 1});
    endfunction

    // drive one byte; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input bit eod, input row_t row, input bit fixed);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_in_byte     <= b;
        s_end_of_data <= eod;
        do @(posedge aclk); while (!s_ready);
        predict_units(b, eod);
        n_items++;
        if (fixed) begin
            units_due.push_back('{row.u0, row.k0, row.nfix == 1});
            if (row.nfix == 2) units_due.push_back('{row.u1, row.k1, 1'b1});
        end else begin
            queue_predicted();
        end
        @(negedge aclk);
    endtask

    task automatic send_plain(input logic [7:0] b, input bit eod);
        send_byte(b, eod, '0, 1'b0);
    endtask

    task automatic send_random_run();
        string hexc, escc;
        int r, len;
        logic [7:0] lead;
        hexc = "0123456789abcdefABCDEF";
        escc = "\"\\/bfnrtu";
        r = $urandom_range(0, 9);
        case (r)
            0, 1: send_plain(8'($urandom_range(32, 126)), 1'b0);
            2: begin
                send_plain(8'h5c, 1'b0);
                if ($urandom_range(0, 5) == 0) send_plain(8'($urandom), $urandom_range(0, 3) == 0);
                else send_plain(escc[$urandom_range(0, 7)], 1'b0);
            end
            3, 4: begin
                send_plain(8'h5c, 1'b0);
                send_plain(8'h75, 1'b0);
                for (int i = 0; i < 4; i++) begin
                    if ($urandom_range(0, 11) == 0) begin
                        send_plain(8'($urandom), $urandom_range(0, 2) == 0);
                        break;
                    end
                    send_plain(hexc[$urandom_range(0, 21)], $urandom_range(0, 15) == 0);
                end
            end
            5, 6: begin
                len = $urandom_range(2, 6);
                lead = 8'(((16'hff00 >> len) & 8'hfe) | ($urandom & (8'h7f >> len)));
                send_plain(lead, 1'b0);
                for (int i = 1; i < len; i++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        send_plain(8'($urandom), 1'b1);
                        break;
                    end
                    send_plain(8'h80 | 8'($urandom_range(0, 63)), 1'b0);
                end
            end
            7: send_plain(8'h22, $urandom_range(0, 3) == 0);
            8: send_plain(8'($urandom), 1'b0);
            default: send_plain(8'($urandom), 1'b1);
        endcase
    endtask

    // result side: random stall before each transfer
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (m_hold > 0) begin
            m_ready <= 1'b0;
            m_hold  <= m_hold - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        unit_rec_t want;
        if (aresetn && m_valid && m_ready) begin
            m_hold <= no_idle ? 0 : $urandom_range(0, 7);
            if (m_unit_kind == KIND_QUOTE) n_quotes++;
            else if (m_unit_kind == KIND_END) n_ends++;
            else n_units++;
            if (units_due.size() == 0) begin
                report_mismatch($sformatf("unexpected unit %h kind %0d",
                                          m_code_unit, m_unit_kind));
            end else begin
                want = units_due.pop_front();
                if (m_code_unit !== want.unit)
                    report_mismatch($sformatf("code unit %h, want %h", m_code_unit, want.unit));
                if (m_unit_kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", m_unit_kind, want.kind));
                if (m_last_of_run !== want.last)
                    report_mismatch($sformatf("last %b, want %b", m_last_of_run, want.last));
            end
        end
    end

    initial begin
        int wait_n;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_in_byte = '0;
        s_end_of_data = 1'b0;
        m_hold = 0;
        no_idle = 1'b0;
        n_errors = 0;
        n_items = 0;
        n_units = 0;
        n_quotes = 0;
        n_ends = 0;
        clear_decoder();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < N_ROWS; i++)
            send_byte(dir_rows[i].b, dir_rows[i].eod, dir_rows[i], dir_rows[i].nfix != 0);

        while (n_items < 180) begin
            if ($urandom_range(0, 24) == 0) no_idle = !no_idle;
            send_random_run();
        end
        s_valid <= 1'b0;
        no_idle = 1'b0;

        wait_n = 0;
        while (units_due.size() != 0 && wait_n < 20000) begin
            @(posedge aclk);
            wait_n++;
        end
        repeat (40) @(posedge aclk);
        if (units_due.size() != 0)
            report_mismatch($sformatf("%0d units never arrived", units_due.size()));

        $display("%0d bytes sent; %0d code units, %0d quote closes, %0d data ends checked",
                 n_items, n_units, n_quotes, n_ends);
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
